// ===== rtl/bts_pkg.sv =====
// shared types, constants and the length decode table of the bm25 term scorer
`timescale 1ns / 1ps

package bts_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_DOCS_IN_FIELD  = 2'd0;
  localparam logic [1:0] CFG_DOCS_WITH_TERM = 2'd1;
  localparam logic [1:0] CFG_TOTAL_TERMS    = 2'd2;

  // round(ln2 * 2^32)
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam int unsigned IDF_W = 38;  // idf in q.32
  localparam int unsigned DEN_W = 99;  // widest divisor

  typedef enum logic [2:0] {
    IDF_LOAD,
    IDF_NORM,
    IDF_SQR,
    IDF_MUL_LO,
    IDF_MUL_HI,
    IDF_READY
  } idf_state_e;

  // norm byte to document length
  function automatic logic [31:0] length_rom(input logic [7:0] idx);
    logic [7:0]  j;
    logic [4:0]  sh;
    logic [31:0] mant;
    j    = idx - 8'd24;
    sh   = 5'(j[7:3] - 5'd1);
    mant = {28'd0, 1'b1, j[2:0]};
    if (idx < 8'd24) begin
      return {24'd0, idx};
    end else if (j < 8'd8) begin
      return 32'd24 + {29'd0, j[2:0]};
    end else begin
      return 32'd24 + (mant << sh);
    end
  endfunction

endpackage

// ===== rtl/bts_idf.sv =====
// idf unit: iterative log2 of both document counts, then scaling by ln2
`timescale 1ns / 1ps

module bts_idf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [30:0]               docs_i,
  input  logic [30:0]               term_docs_i,
  output logic [bts_pkg::IDF_W-1:0] idf_o,
  output logic                      busy_o
);

  bts_pkg::idf_state_e state_q, state_d;
  logic                      sel_q, sel_d;
  logic [32:0]               w_q, w_d;
  logic [5:0]                e_q, e_d;
  logic [31:0]               m_q, m_d;
  logic [31:0]               frac_q, frac_d;
  logic [4:0]                cnt_q, cnt_d;
  logic [bts_pkg::IDF_W-1:0] la_q, la_d;
  logic [bts_pkg::IDF_W-1:0] d_q, d_d;
  logic [63:0]               acc_q, acc_d;
  logic [bts_pkg::IDF_W-1:0] idf_q, idf_d;

  logic [63:0]               sq;
  logic [32:0]               m2;
  logic [31:0]               frac_n;
  logic [bts_pkg::IDF_W-1:0] log_n;
  logic [69:0]               prod;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    w_d     = w_q;
    e_d     = e_q;
    m_d     = m_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    la_d    = la_q;
    d_d     = d_q;
    acc_d   = acc_q;
    idf_d   = idf_q;
    sq      = 64'(m_q) * 64'(m_q);
    m2      = sq[63:31];
    frac_n  = {frac_q[30:0], m2[32]};
    log_n   = {e_q, frac_n};
    prod    = 70'(acc_q) + ((70'(d_q[37:32]) * 70'(bts_pkg::LN2_Q32)) << 32);
    case (state_q)
      bts_pkg::IDF_LOAD: begin
        w_d     = sel_q ? (33'({term_docs_i, 1'b0}) + 33'd1)
                        : (33'({docs_i, 1'b0}) + 33'd2);
        e_d     = 6'd32;
        state_d = bts_pkg::IDF_NORM;
      end
      bts_pkg::IDF_NORM: begin
        if (w_q[32]) begin
          m_d     = w_q[32:1];
          cnt_d   = 5'd0;
          frac_d  = 32'd0;
          state_d = bts_pkg::IDF_SQR;
        end else begin
          w_d = w_q << 1;
          e_d = e_q - 6'd1;
        end
      end
      bts_pkg::IDF_SQR: begin
        // one squaring per cycle gives one fraction bit
        m_d    = m2[32] ? m2[32:1] : m2[31:0];
        frac_d = frac_n;
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          if (!sel_q) begin
            la_d    = log_n;
            sel_d   = 1'b1;
            state_d = bts_pkg::IDF_LOAD;
          end else begin
            d_d     = (la_q > log_n) ? (la_q - log_n) : '0;
            state_d = bts_pkg::IDF_MUL_LO;
          end
        end
      end
      bts_pkg::IDF_MUL_LO: begin
        acc_d   = 64'(d_q[31:0]) * 64'(bts_pkg::LN2_Q32);
        state_d = bts_pkg::IDF_MUL_HI;
      end
      bts_pkg::IDF_MUL_HI: begin
        idf_d   = prod[69:32];
        state_d = bts_pkg::IDF_READY;
      end
      bts_pkg::IDF_READY: begin
      end
      default: begin
        state_d = bts_pkg::IDF_LOAD;
      end
    endcase
    if (start_i) begin
      state_d = bts_pkg::IDF_LOAD;
      sel_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bts_pkg::IDF_LOAD;
      sel_q   <= 1'b0;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    e_q    <= e_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    la_q   <= la_d;
    d_q    <= d_d;
    acc_q  <= acc_d;
    idf_q  <= idf_d;
  end

  assign idf_o  = idf_q;
  assign busy_o = (state_q != bts_pkg::IDF_READY);

endmodule

// ===== rtl/bm25_term_scorer.sv =====
// bm25 term scorer top level: config registers, scoring pipeline, output register
`timescale 1ns / 1ps

// Scores one posting per cycle with BM25 (k1 1.2, b 0.75). The result sits in the
// output register after the input beat has passed through 38 register
// stages: four stages of decode, partial products, sums and divisor, 32
// long-division stages (one quotient bit each) and two stages of idf multiply and
// rounding. The idf depends only on configuration and is computed
// by a separate iterative unit after reset and after every configuration write;
// while it runs its two bit-serial log2 passes
// in_stall_o is held high. After that one beat per cycle is taken, limited only
// by out_stall_i. score_error_o flags a zero document count, a zero total or a
// term count above the document count; the score is then 0.
module bm25_term_scorer #(
  parameter int unsigned SCORE_FRAC_BITS = 27
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [62:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [30:0] term_frequency_i,
  input  logic [7:0]  norm_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] score_o,
  output logic        score_error_o
);

  localparam int unsigned SHIFT = 64 - SCORE_FRAC_BITS;
  localparam int unsigned DW    = bts_pkg::DEN_W;
  localparam int unsigned NSTEP = 32;

  logic [30:0] nd_q, nt_q;
  logic [62:0] tt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q <= 31'd1;
      nt_q <= 31'd1;
      tt_q <= 63'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bts_pkg::CFG_DOCS_IN_FIELD:  nd_q <= cfg_data_i[30:0];
        bts_pkg::CFG_DOCS_WITH_TERM: nt_q <= cfg_data_i[30:0];
        bts_pkg::CFG_TOTAL_TERMS:    tt_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic [bts_pkg::IDF_W-1:0] idf;
  logic                      idf_busy;

  bts_idf u_idf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cfg_we_i),
    .docs_i      (nd_q),
    .term_docs_i (nt_q),
    .idf_o       (idf),
    .busy_o      (idf_busy)
  );

  logic advance;
  logic in_accept;
  logic cfg_err;

  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance || idf_busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_err    = (nd_q == 31'd0) || (tt_q == 63'd0) || (nt_q > nd_q);

  // stage 1: decode
  logic        v1_q, e1_q;
  logic [34:0] f10_q;
  logic [35:0] l9_q;
  // stage 2: partial products
  logic        v2_q, e2_q;
  logic [63:0] pp0_q;
  logic [34:0] pp1_q;
  logic [62:0] pp2_q;
  logic [33:0] pp3_q;
  logic [62:0] pc0_q;
  logic [34:0] pc1_q;
  // stage 3: sums
  logic        v3_q, e3_q;
  logic [97:0] a3_q;
  logic [66:0] c3_q;

  logic [31:0] len;
  assign len = bts_pkg::length_rom(norm_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      e1_q  <= cfg_err;
      f10_q <= (35'(term_frequency_i) << 3) + (35'(term_frequency_i) << 1);
      l9_q  <= (36'(len) << 3) + 36'(len);
      e2_q  <= e1_q;
      pp0_q <= 64'(tt_q[31:0]) * 64'(f10_q[31:0]);
      pp1_q <= 35'(tt_q[31:0]) * 35'(f10_q[34:32]);
      pp2_q <= 63'(tt_q[62:32]) * 63'(f10_q[31:0]);
      pp3_q <= 34'(tt_q[62:32]) * 34'(f10_q[34:32]);
      pc0_q <= 63'(l9_q[31:0]) * 63'(nd_q);
      pc1_q <= 35'(l9_q[35:32]) * 35'(nd_q);
      e3_q  <= e2_q;
      a3_q  <= 98'(pp0_q) + (98'(pp1_q) << 32) + (98'(pp2_q) << 32) + (98'(pp3_q) << 64);
      c3_q  <= 67'(pc0_q) + (67'(pc1_q) << 32);
    end
  end

  // division chain, index 0 is stage 4
  logic          v_q   [0:NSTEP];
  logic          e_q   [0:NSTEP];
  logic [DW-1:0] rem_q [0:NSTEP];
  logic [DW-1:0] den_q [0:NSTEP];
  logic [31:0]   qt_q  [1:NSTEP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (advance) begin
      v_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      e_q[0]   <= e3_q;
      rem_q[0] <= DW'(a3_q);
      den_q[0] <= DW'(a3_q) + (DW'(tt_q) << 1) + DW'(tt_q) + DW'(c3_q);
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_div
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_d;
    logic [31:0]   qprev;

    if (k == 1) begin : g_first
      assign qprev = 32'd0;
    end else begin : g_rest
      assign qprev = qt_q[k-1];
    end

    always_comb begin
      trial = {rem_q[k-1], 1'b0};
      ge    = (trial >= {1'b0, den_q[k-1]});
      rem_d = ge ? DW'(trial - {1'b0, den_q[k-1]}) : trial[DW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (advance) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        e_q[k]   <= e_q[k-1];
        rem_q[k] <= rem_d;
        den_q[k] <= den_q[k-1];
        qt_q[k]  <= {qprev[30:0], ge};
      end
    end
  end

  // idf times ratio
  logic        vm_q, em_q;
  logic [63:0] pl_q;
  logic [37:0] ph_q;
  logic        out_valid_q, err_q;
  logic [31:0] score_q;

  logic [69:0] prod;
  logic [70:0] rounded;
  logic [70:0] shifted;
  logic [31:0] score_d;

  always_comb begin
    prod    = 70'(pl_q) + (70'(ph_q) << 32);
    rounded = 71'(prod) + (71'(1) << (SHIFT - 1));
    shifted = rounded >> SHIFT;
    score_d = (|shifted[70:32]) ? 32'hFFFF_FFFF : shifted[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      vm_q        <= v_q[NSTEP];
      out_valid_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      em_q    <= e_q[NSTEP];
      pl_q    <= 64'(qt_q[NSTEP]) * 64'(idf[31:0]);
      ph_q    <= 38'(qt_q[NSTEP]) * 38'(idf[37:32]);
      err_q   <= em_q;
      score_q <= em_q ? 32'd0 : score_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign score_o       = score_q;
  assign score_error_o = err_q;

endmodule

// ===== rtl/bts_checker.sv =====
// port-level checks of the bm25 term scorer, bound to the top level
`timescale 1ns / 1ps

module bts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] score_o,
  input logic        score_error_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(score_o) && $stable(score_error_o))
    else $error("stalled result beat changed");

  // error beats carry a zero score
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && score_error_o |-> score_o == 32'd0)
    else $error("error beat with nonzero score");

  // idf recompute blocks input after a config write
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input taken right after config write");

  // output backpressure reaches the input side
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");

endmodule

bind bm25_term_scorer bts_checker u_bts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .score_o       (score_o),
  .score_error_o (score_error_o)
);
